>>> design/ihc_pkg.sv
`timescale 1ns / 1ps
// Package for the IPv4 header checker: verdict codes, item and result types,
// header constants and the ones-complement adder. No dependencies.
package ihc_pkg;

	typedef enum logic [2:0] {
		VERDICT_ACCEPT  = 3'd0,
		VERDICT_ICMP    = 3'd1,
		VERDICT_BADHDR  = 3'd2,
		VERDICT_BADSUM  = 3'd3,
		VERDICT_BADLEN  = 3'd4,
		VERDICT_TRUNC   = 3'd5
	} verdict_t;

	localparam logic [7:0]  PROTO_ICMP    = 8'd1;
	localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
	localparam logic [3:0]  IP_VERSION    = 4'd4;
	localparam logic [3:0]  MIN_IHL       = 4'd5;
	localparam logic [15:0] SUM_GOOD      = 16'hFFFF;

	localparam logic [5:0] IDX_VER_IHL = 6'd0;
	localparam logic [5:0] IDX_TLEN_HI = 6'd2;
	localparam logic [5:0] IDX_TLEN_LO = 6'd3;
	localparam logic [5:0] IDX_PROTO   = 6'd9;

	typedef struct packed {
		logic [7:0]  packet_byte;
		logic        first_byte;
		logic        last_byte;
		logic [15:0] frame_length;
	} byte_item_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [5:0]  header_length;
		logic [7:0]  protocol;
		logic [15:0] trim_bytes;
	} result_t;

	// 16-bit add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		begin
			s = {1'b0, a} + {1'b0, b};
			oc_add = s[15:0] + {15'd0, s[16]};
		end
	endfunction

endpackage

>>> design/ihc_pkt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one packet byte with its framing marks.
// Standalone; no package dependency.
interface ihc_pkt_if;
	logic        valid;
	logic        ready;
	logic [7:0]  packet_byte;
	logic        first_byte;
	logic        last_byte;
	logic [15:0] frame_length;

	modport source (output valid, packet_byte, first_byte, last_byte, frame_length,
		input ready);
	modport sink (input valid, packet_byte, first_byte, last_byte, frame_length,
		output ready);
endinterface

>>> design/ihc_res_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one header verdict item.
// Standalone; no package dependency.
interface ihc_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [5:0]  header_length;
	logic [7:0]  protocol;
	logic [15:0] trim_bytes;

	modport source (output valid, verdict, header_length, protocol, trim_bytes,
		input ready);
	modport sink (input valid, verdict, header_length, protocol, trim_bytes,
		output ready);
endinterface

>>> design/ihc_hdr_track.sv
`timescale 1ns / 1ps
// Per-packet header state and the per-byte update/verdict logic.
// Depends on ihc_pkg.
module ihc_hdr_track (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  ihc_pkg::byte_item_t item,
	input  logic               drop_icmp,
	output logic               res_valid,
	output ihc_pkg::result_t   res
);
	import ihc_pkg::*;

	logic [5:0]  byte_index_q;
	logic        header_done_q;
	logic [7:0]  version_ihl_q;
	logic [7:0]  proto_q;
	logic [15:0] total_len_q;
	logic [15:0] sum_q;
	logic [7:0]  high_half_q;
	logic [15:0] frame_len_q;

	logic        first, active, done;
	logic [5:0]  idx;
	logic [7:0]  vi_e, vi_n, proto_e, proto_n, high_e, high_n;
	logic [15:0] tl_e, tl_n, sum_e, sum_n, flen_e, trim;
	logic [3:0]  ihl;
	logic [5:0]  hl, need;
	logic [6:0]  idx_inc;
	verdict_t    verdict;

	always_comb begin
		first   = item.first_byte;
		active  = first || !header_done_q;
		// a first byte starts from a cleared packet state
		idx     = first ? 6'd0  : byte_index_q;
		vi_e    = first ? 8'd0  : version_ihl_q;
		proto_e = first ? 8'd0  : proto_q;
		tl_e    = first ? 16'd0 : total_len_q;
		sum_e   = first ? 16'd0 : sum_q;
		high_e  = first ? 8'd0  : high_half_q;
		flen_e  = first ? item.frame_length : frame_len_q;

		vi_n    = (idx == IDX_VER_IHL) ? item.packet_byte : vi_e;
		proto_n = (idx == IDX_PROTO) ? item.packet_byte : proto_e;
		tl_n    = tl_e;
		if (idx == IDX_TLEN_HI) begin
			tl_n = {item.packet_byte, tl_e[7:0]};
		end else if (idx == IDX_TLEN_LO) begin
			tl_n = {tl_e[15:8], item.packet_byte};
		end

		ihl  = vi_n[3:0];
		hl   = {ihl, 2'b00};
		need = (ihl >= MIN_IHL) ? hl : MIN_HDR_BYTES;

		high_n = high_e;
		sum_n  = sum_e;
		if (idx < hl) begin
			if (!idx[0]) begin
				high_n = item.packet_byte;
			end else begin
				sum_n = oc_add(sum_e, {high_e, item.packet_byte});
			end
		end

		idx_inc = {1'b0, idx} + 7'd1;
		done    = idx_inc >= {1'b0, need};

		trim = 16'd0;
		priority if (drop_icmp && proto_n == PROTO_ICMP) begin
			verdict = VERDICT_ICMP;
		end else if (vi_n[7:4] != IP_VERSION || hl < MIN_HDR_BYTES) begin
			verdict = VERDICT_BADHDR;
		end else if (sum_n != SUM_GOOD) begin
			verdict = VERDICT_BADSUM;
		end else if (flen_e < tl_n || tl_n < {10'd0, hl}) begin
			verdict = VERDICT_BADLEN;
		end else begin
			verdict = VERDICT_ACCEPT;
			trim    = flen_e - tl_n;
		end

		res_valid         = item_valid && active && (done || item.last_byte);
		res.verdict       = done ? verdict : VERDICT_TRUNC;
		res.header_length = hl;
		res.protocol      = proto_n;
		res.trim_bytes    = done ? trim : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= '0;
			header_done_q <= 1'b1;
			version_ihl_q <= '0;
			proto_q       <= '0;
			total_len_q   <= '0;
			sum_q         <= '0;
			high_half_q   <= '0;
			frame_len_q   <= '0;
		end else if (item_valid && active) begin
			byte_index_q  <= idx_inc[5:0];
			header_done_q <= done || item.last_byte;
			version_ihl_q <= vi_n;
			proto_q       <= proto_n;
			total_len_q   <= tl_n;
			sum_q         <= sum_n;
			high_half_q   <= high_n;
			frame_len_q   <= flen_e;
		end
	end

endmodule

>>> design/ipv4_header_checker_unit.sv
`timescale 1ns / 1ps
// IPv4 header checker, top level. Depends on ihc_pkg, ihc_pkt_if, ihc_res_if,
// ihc_hdr_track.
// Pipeline: a byte accepted into the input register (item_s1) passes through the header
// update/verdict logic, which loads the result register (res_q) that drives the result
// outputs. A byte waits in the input register while a result is held.
// Throughput: one byte per cycle, sustained while results are taken.
// Reset (arst_n low): pipeline empty, waiting for a first byte, drop_icmp = 1.
module ipv4_header_checker_unit (
	input  logic       clk,
	input  logic       arst_n,
	ihc_pkt_if.sink    pkt,
	ihc_res_if.source  result,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data
);
	import ihc_pkg::*;

	logic       drop_icmp_q;
	logic       valid_s1;
	byte_item_t item_s1;
	logic       out_valid_q;
	result_t    res_q;
	logic       adv;
	logic       step_valid;
	result_t    step_res;

	assign adv       = !out_valid_q || result.ready;
	assign pkt.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_icmp_q <= 1'b1;
		end else if (cfg_wr_en) begin
			drop_icmp_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			item_s1.packet_byte  <= pkt.packet_byte;
			item_s1.first_byte   <= pkt.first_byte;
			item_s1.last_byte    <= pkt.last_byte;
			item_s1.frame_length <= pkt.frame_length;
		end
	end

	ihc_hdr_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1 && adv),
		.item       (item_s1),
		.drop_icmp  (drop_icmp_q),
		.res_valid  (step_valid),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step_valid) begin
			res_q <= step_res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.verdict       = res_q.verdict;
	assign result.header_length = res_q.header_length;
	assign result.protocol      = res_q.protocol;
	assign result.trim_bytes    = res_q.trim_bytes;

	// input side only stalls when both stages are full and the result is held
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pkt.ready |-> (valid_s1 && out_valid_q && !result.ready))
		else $error("input stalled without a held result");

	// a new result needs a byte in the input register on the cycle before
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a processed byte");

	// trim is only nonzero for accepted packets
	a_trim_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.verdict != VERDICT_ACCEPT) |-> (res_q.trim_bytes == 16'd0))
		else $error("trim on a rejected packet");

	// an accepted header is at least the minimum length
	a_accept_hl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.verdict == VERDICT_ACCEPT)
		|-> (res_q.header_length >= MIN_HDR_BYTES))
		else $error("accepted header shorter than minimum");

endmodule
